// File: src/bba_pkg.sv
// Package for the bitmap block allocator.
// Holds the transfer structs, status and request codes, controller states
// and the command/status groups between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int CNT_W   = 13;
    localparam int ID_W    = 16;
    localparam int GRANT_W = 12;
    localparam int WORD_W  = 32;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [1:0] STAT_FREED     = 2'd2;
    localparam logic [1:0] STAT_BAD_ID    = 2'd3;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] block_id;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [GRANT_W-1:0] granted_id;
        logic [CNT_W-1:0]   used_blocks;
        logic [CNT_W-1:0]   vacant_blocks;
    } res_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_GRANT,
        S_FREE_CHK,
        S_REPLY
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       clr_write;
        logic       req_load;
        logic       rd_word_id;
        logic       rd_scan_first;
        logic       rd_scan_next;
        logic       grant_write;
        logic       free_write;
        logic       status_load;
        logic [1:0] status_code;
        logic       reply;
    } bba_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic id_bad;
        logic vacant_zero;
        logic scan_found;
        logic scan_last;
        logic bit_set;
    } bba_sts_t;

endpackage

// File: src/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Sequences clearing pass, allocate scan and free; depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     cfg_we,
    input  bba_sts_t sts,
    output bba_cmd_t cmd,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_free)
                begin
                    state_next = sts.id_bad ? S_REPLY : S_FREE_CHK;
                end
                else
                begin
                    state_next = sts.vacant_zero ? S_REPLY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_found)
                begin
                    state_next = S_GRANT;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_REPLY;
                end
            end
            S_GRANT:    state_next = S_REPLY;
            S_FREE_CHK: state_next = S_REPLY;
            S_REPLY:    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        // A register write re-initializes the map
        if (cfg_we)
        begin
            state_next = S_CLEAR;
        end
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
            end
            S_IDLE:
            begin
                cmd.req_load = start;
            end
            S_DECIDE:
            begin
                if (sts.is_free)
                begin
                    if (sts.id_bad)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = STAT_BAD_ID;
                    end
                    else
                    begin
                        cmd.rd_word_id = 1'b1;
                    end
                end
                else if (sts.vacant_zero)
                begin
                    cmd.status_load = 1'b1;
                    cmd.status_code = STAT_NO_SPACE;
                end
                else
                begin
                    cmd.rd_scan_first = 1'b1;
                end
            end
            S_SCAN:
            begin
                // Hold the read word once a free bit shows up
                if (!sts.scan_found)
                begin
                    if (sts.scan_last)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = STAT_NO_SPACE;
                    end
                    else
                    begin
                        cmd.rd_scan_next = 1'b1;
                    end
                end
            end
            S_GRANT:
            begin
                cmd.grant_write = 1'b1;
                cmd.status_load = 1'b1;
                cmd.status_code = STAT_ALLOCATED;
            end
            S_FREE_CHK:
            begin
                cmd.free_write  = sts.bit_set;
                cmd.status_load = 1'b1;
                cmd.status_code = STAT_FREED;
            end
            S_REPLY:
            begin
                cmd.reply = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/bba_datapath.sv
// Datapath of the bitmap block allocator: usage-map memory, counters,
// scan pointer, first-free search and result register; depends on bba_pkg.
`timescale 1ns / 1ps

module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int RESERVED   = 131
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  req_t             req,
    input  bba_cmd_t         cmd,
    output bba_sts_t         sts,
    output logic             done,
    output res_t             result
);

    localparam int WORDS    = (MAX_BLOCKS + 31) / 32;
    localparam int AW       = $clog2(WORDS);
    localparam int RES_FULL = RESERVED / 32;
    localparam int RES_TAIL = RESERVED % 32;
    localparam int MAP_TAIL = MAX_BLOCKS % 32;

    localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
    localparam logic [16:0]       MAX_V     = 17'(MAX_BLOCKS);
    localparam logic [16:0]       RES_V     = 17'(RESERVED);
    localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] TOP_BIT   = {1'b1, {(WORD_W-1){1'b0}}};
    // Bits past the last block in a partial last word count as used
    localparam logic [WORD_W-1:0] PAD_MASK  = (MAP_TAIL == 0) ? '0 : (ONES >> MAP_TAIL);

    // Vacant count right after (re)initialization
    function automatic logic [CNT_W-1:0] vacant_init(input logic [CNT_W-1:0] total);
        logic [16:0] avail;
        avail = (17'(total) > MAX_V) ? MAX_V : 17'(total);
        return (avail > RES_V) ? CNT_W'(avail - RES_V) : '0;
    endfunction

    logic [WORD_W-1:0] map_mem [WORDS];

    req_t              req_reg;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     scan_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  vacant_reg;
    logic [1:0]        status_reg;
    logic [GRANT_W-1:0] granted_reg;
    logic              done_reg;
    res_t              result_reg;

    logic [AW-1:0]     id_word;
    logic [4:0]        id_off;
    logic [WORD_W-1:0] id_bit;
    logic [WORD_W-1:0] init_word;
    logic [WORD_W-1:0] scan_word;
    logic [4:0]        free_off;
    logic              free_hit;
    logic [16:0]       grant_blk;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              mem_re;
    logic [AW-1:0]     rd_addr;

    assign id_word = req_reg.block_id[AW+4:5];
    assign id_off  = req_reg.block_id[4:0];
    assign id_bit  = TOP_BIT >> id_off;

    // Reset pattern of the word under the clearing pointer
    always_comb
    begin
        if (clr_reg < AW'(RES_FULL))
        begin
            init_word = ONES;
        end
        else if (clr_reg == AW'(RES_FULL))
        begin
            init_word = ~(ONES >> RES_TAIL);
        end
        else
        begin
            init_word = '0;
        end
    end

    // Scanned word with blocks past the map end marked used
    assign scan_word = (scan_reg == LAST_WORD) ? (rd_word_reg | PAD_MASK) : rd_word_reg;

    // Find the lowest clear block, searching from bit 31 down
    always_comb
    begin
        free_off = '0;
        free_hit = 1'b0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (!free_hit && !scan_word[WORD_W-1-j])
            begin
                free_off = 5'(j);
                free_hit = 1'b1;
            end
        end
    end

    assign grant_blk = 17'({scan_reg, free_off});

    // Status to the controller
    always_comb
    begin
        sts.clr_last    = (clr_reg == LAST_WORD);
        sts.is_free     = (req_reg.kind == KIND_FREE);
        sts.id_bad      = (req_reg.block_id < ID_W'(RESERVED))
                          || (17'(req_reg.block_id) >= MAX_V);
        sts.vacant_zero = (vacant_reg == '0);
        sts.scan_found  = free_hit;
        sts.scan_last   = (scan_reg == LAST_WORD);
        sts.bit_set     = ((rd_word_reg & id_bit) != '0);
    end

    // Memory port selection
    always_comb
    begin
        mem_we  = cmd.clr_write | cmd.grant_write | cmd.free_write;
        wr_addr = clr_reg;
        wr_data = init_word;
        if (cmd.grant_write)
        begin
            wr_addr = scan_reg;
            wr_data = rd_word_reg | (TOP_BIT >> free_off);
        end
        else if (cmd.free_write)
        begin
            wr_addr = id_word;
            wr_data = rd_word_reg & ~id_bit;
        end
        mem_re  = cmd.rd_word_id | cmd.rd_scan_first | cmd.rd_scan_next;
        rd_addr = '0;
        if (cmd.rd_word_id)
        begin
            rd_addr = id_word;
        end
        else if (cmd.rd_scan_next)
        begin
            rd_addr = scan_reg + 1'b1;
        end
    end

    // Usage map: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_word_reg <= map_mem[rd_addr];
        end
    end

    // Request, status and grant holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg     <= req;
            granted_reg <= '0;
        end
        if (cmd.status_load)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.grant_write)
        begin
            granted_reg <= grant_blk[GRANT_W-1:0];
        end
        if (cmd.reply)
        begin
            result_reg.status        <= status_reg;
            result_reg.granted_id    <= granted_reg;
            result_reg.used_blocks   <= used_reg;
            result_reg.vacant_blocks <= vacant_reg;
        end
    end

    // Counters, clearing and scan pointers, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            scan_reg   <= '0;
            used_reg   <= CNT_W'(RESERVED);
            vacant_reg <= vacant_init(TOTAL_RESET);
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply;
            if (cfg_we)
            begin
                clr_reg    <= '0;
                used_reg   <= CNT_W'(RESERVED);
                vacant_reg <= vacant_init(cfg_wdata);
            end
            else
            begin
                if (cmd.clr_write)
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                if (cmd.grant_write)
                begin
                    used_reg   <= used_reg + 1'b1;
                    vacant_reg <= vacant_reg - 1'b1;
                end
                else if (cmd.free_write)
                begin
                    used_reg   <= used_reg - 1'b1;
                    vacant_reg <= vacant_reg + 1'b1;
                end
            end
            if (cmd.rd_scan_first)
            begin
                scan_reg <= '0;
            end
            else if (cmd.rd_scan_next)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: src/bitmap_block_allocator.sv
// Top level of the bitmap block allocator.
// Joins bba_ctrl and bba_datapath; depends on bba_pkg.
`timescale 1ns / 1ps

// Takes one request at a time: a request transfers on a clock edge with start
// high and busy low, and its single result appears on result with done high for
// exactly one cycle; the receiver must take it then. A free request reads the
// word that holds its id, clears the bit if it is set and replies; an id that
// is reserved or out of range replies without a read. An allocate with no
// vacancy replies without a scan; otherwise the usage-map memory is scanned
// one 32-bit word per cycle through its single read port until a clear block
// turns up, which is granted, or all (MAX_BLOCKS+31)/32 words have been read.
// After reset and after every write of total_blocks a clearing pass rewrites
// the map, and busy stays high throughout.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int RESERVED   = 131
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  req_t             req,
    output logic             busy,
    output logic             done,
    output res_t             result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .RESERVED   (RESERVED)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );

endmodule

// File: src/bba_checker.sv
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_checker
    import bba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    // Only an allocation carries a block id
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_ALLOCATED) |-> (result.granted_id == '0))
        else $error("granted_id nonzero on a result that is not an allocation");

    // One result per request: done falls again after each strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high on two consecutive cycles");

    // A transferred request keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a request transfer");

    // No result in the cycle right after a transfer
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result appeared one cycle after a transfer");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
